>>> src/gtb_pkg.sv
`default_nettype none
package gtb_pkg;

  localparam int ROWS = 32;
  localparam int VW   = 5;
  localparam int PW   = 6;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_BFS   = 2'd1,
    OP_DFS   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BFS_READ,
    ST_BFS_LOAD,
    ST_BFS_SCAN,
    ST_DFS_SCAN,
    ST_DFS_LOAD,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic wr_row;
    logic start_bfs;
    logic start_dfs;
    logic set_bad;
    logic rd_head;
    logic load_bfs;
    logic push_bfs;
    logic push_dfs;
    logic pop_rd;
    logic pop_load;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic bad_start;
    logic cand_any;
    logic queue_empty;
    logic stack_empty;
    logic emit_ok;
    logic out_free;
    logic pend_valid;
  } sts_t;

  function automatic logic [VW-1:0] lowest_bit(input logic [ROWS-1:0] v);
    logic [VW-1:0] r;
    r = '0;
    for (int i = ROWS - 1; i >= 0; i--) begin
      if (v[i]) r = VW'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/gtb_in_if.sv
`default_nettype none
interface gtb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [4:0]  row_index;
  logic [31:0] row_bits;
  logic [4:0]  start_vertex;
  modport source (output valid, operation, row_index, row_bits, start_vertex, input ready);
  modport sink   (input valid, operation, row_index, row_bits, start_vertex, output ready);
endinterface
`default_nettype wire

>>> src/gtb_out_if.sv
`default_nettype none
interface gtb_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] vertex;
  logic       last;
  logic       bad_start;
  modport source (output valid, vertex, last, bad_start, input ready);
  modport sink   (input valid, vertex, last, bad_start, output ready);
endinterface
`default_nettype wire

>>> src/gtb_ctrl.sv
`default_nettype none
module gtb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_op,
  output logic               in_ready,
  input  wire gtb_pkg::sts_t sts,
  output gtb_pkg::cmd_t      cmd
);

  gtb_pkg::state_t state_r, state_nxt;
  gtb_pkg::op_t    op;

  assign op = gtb_pkg::op_t'(in_op);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gtb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      gtb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (op)
            gtb_pkg::OP_WRITE: cmd.wr_row = 1'b1;
            gtb_pkg::OP_BFS, gtb_pkg::OP_DFS: begin
              if (sts.bad_start) begin
                cmd.set_bad = 1'b1;
                state_nxt   = gtb_pkg::ST_FLUSH;
              end else if (op == gtb_pkg::OP_BFS) begin
                cmd.start_bfs = 1'b1;
                state_nxt     = gtb_pkg::ST_BFS_READ;
              end else begin
                cmd.start_dfs = 1'b1;
                state_nxt     = gtb_pkg::ST_DFS_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      gtb_pkg::ST_BFS_READ: begin
        cmd.rd_head = 1'b1;
        state_nxt   = gtb_pkg::ST_BFS_LOAD;
      end
      gtb_pkg::ST_BFS_LOAD: begin
        if (sts.emit_ok) begin
          cmd.load_bfs = 1'b1;
          state_nxt    = gtb_pkg::ST_BFS_SCAN;
        end
      end
      gtb_pkg::ST_BFS_SCAN: begin
        if (sts.cand_any) begin
          cmd.push_bfs = 1'b1;
        end else if (sts.queue_empty) begin
          state_nxt = gtb_pkg::ST_FLUSH;
        end else begin
          state_nxt = gtb_pkg::ST_BFS_READ;
        end
      end
      gtb_pkg::ST_DFS_SCAN: begin
        if (sts.cand_any) begin
          if (sts.emit_ok) cmd.push_dfs = 1'b1;
        end else if (sts.stack_empty) begin
          state_nxt = gtb_pkg::ST_FLUSH;
        end else begin
          cmd.pop_rd = 1'b1;
          state_nxt  = gtb_pkg::ST_DFS_LOAD;
        end
      end
      gtb_pkg::ST_DFS_LOAD: begin
        cmd.pop_load = 1'b1;
        state_nxt    = gtb_pkg::ST_DFS_SCAN;
      end
      gtb_pkg::ST_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = gtb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gtb_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> src/gtb_dp.sv
`default_nettype none
module gtb_dp #(
  parameter int NODES = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [5:0]    cfg_data,
  input  wire logic [4:0]    in_row_index,
  input  wire logic [31:0]   in_row_bits,
  input  wire logic [4:0]    in_start_vertex,
  input  wire gtb_pkg::cmd_t cmd,
  output gtb_pkg::sts_t      sts,
  input  wire logic          out_ready,
  output logic               out_valid,
  output logic [4:0]         out_vertex,
  output logic               out_last,
  output logic               out_bad_start
);

  localparam int CAP = (NODES < gtb_pkg::ROWS) ? NODES : gtb_pkg::ROWS;

  logic [gtb_pkg::ROWS-1:0] adj_r [gtb_pkg::ROWS];
  logic [gtb_pkg::VW-1:0]   ord_mem [gtb_pkg::ROWS];
  logic [gtb_pkg::VW-1:0]   rd_r;
  logic [gtb_pkg::ROWS-1:0] vis_r;
  logic [gtb_pkg::PW-1:0]   head_r, tail_r, vc_r, eff;
  logic [gtb_pkg::VW-1:0]   cur_r;
  logic                     pend_valid_r, pend_bad_r;
  logic [gtb_pkg::VW-1:0]   pend_v_r;
  logic                     out_valid_r, out_last_r, out_bad_r;
  logic [gtb_pkg::VW-1:0]   out_v_r;

  logic [gtb_pkg::ROWS-1:0] mask, cand;
  logic [gtb_pkg::VW-1:0]   low, emit_v, wa, wd, ra;
  logic                     emit_now, mem_we, mem_re, out_free;

  assign eff = (vc_r > gtb_pkg::PW'(CAP)) ? gtb_pkg::PW'(CAP) : vc_r;

  always_comb begin
    for (int i = 0; i < gtb_pkg::ROWS; i++) begin
      mask[i] = (gtb_pkg::PW'(i) < eff);
    end
  end

  assign cand = adj_r[cur_r] & ~vis_r & mask;
  assign low  = gtb_pkg::lowest_bit(cand);

  assign emit_now = cmd.load_bfs | cmd.start_dfs | cmd.push_dfs;
  assign emit_v   = cmd.load_bfs ? rd_r : (cmd.start_dfs ? in_start_vertex : low);

  // queue for breadth-first, stack for depth-first
  always_comb begin
    mem_we = cmd.start_bfs | cmd.push_bfs | cmd.push_dfs;
    wa     = tail_r[gtb_pkg::VW-1:0];
    wd     = cmd.push_dfs ? cur_r : low;
    if (cmd.start_bfs) begin
      wa = '0;
      wd = in_start_vertex;
    end
    mem_re = cmd.rd_head | cmd.pop_rd;
    ra     = cmd.rd_head ? head_r[gtb_pkg::VW-1:0]
                         : gtb_pkg::VW'(tail_r - gtb_pkg::PW'(1));
  end

  always_ff @(posedge clk) begin
    if (mem_we) ord_mem[wa] <= wd;
    if (mem_re) rd_r <= ord_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gtb_pkg::ROWS; i++) adj_r[i] <= '0;
    end else if (cmd.wr_row && (int'(in_row_index) < NODES)) begin
      adj_r[in_row_index] <= in_row_bits;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r         <= gtb_pkg::PW'(32);
      vis_r        <= '0;
      head_r       <= '0;
      tail_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) vc_r <= cfg_data;
      if (cmd.start_bfs || cmd.start_dfs) begin
        vis_r  <= {{(gtb_pkg::ROWS-1){1'b0}}, 1'b1} << in_start_vertex;
        head_r <= '0;
        tail_r <= cmd.start_bfs ? gtb_pkg::PW'(1) : '0;
      end
      if (cmd.start_dfs) cur_r <= in_start_vertex;
      if (cmd.load_bfs) begin
        cur_r  <= rd_r;
        head_r <= head_r + gtb_pkg::PW'(1);
      end
      if (cmd.push_bfs || cmd.push_dfs) begin
        vis_r[low] <= 1'b1;
        tail_r     <= tail_r + gtb_pkg::PW'(1);
      end
      if (cmd.push_dfs) cur_r <= low;
      if (cmd.pop_rd) tail_r <= tail_r - gtb_pkg::PW'(1);
      if (cmd.pop_load) cur_r <= rd_r;

      // pending result held back one step so the final one can carry last
      if (emit_now) begin
        if (pend_valid_r) begin
          out_valid_r <= 1'b1;
          out_v_r     <= pend_v_r;
          out_last_r  <= 1'b0;
          out_bad_r   <= pend_bad_r;
        end else if (out_ready) begin
          out_valid_r <= 1'b0;
        end
        pend_valid_r <= 1'b1;
        pend_v_r     <= emit_v;
        pend_bad_r   <= 1'b0;
      end else if (cmd.flush) begin
        out_valid_r  <= 1'b1;
        out_v_r      <= pend_v_r;
        out_last_r   <= 1'b1;
        out_bad_r    <= pend_bad_r;
        pend_valid_r <= 1'b0;
      end else begin
        if (out_ready) out_valid_r <= 1'b0;
        if (cmd.set_bad) begin
          pend_valid_r <= 1'b1;
          pend_v_r     <= '0;
          pend_bad_r   <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    sts.bad_start   = ({1'b0, in_start_vertex} >= eff);
    sts.cand_any    = |cand;
    sts.queue_empty = (head_r == tail_r);
    sts.stack_empty = (tail_r == '0);
    sts.emit_ok     = !pend_valid_r || out_free;
    sts.out_free    = out_free;
    sts.pend_valid  = pend_valid_r;
  end

  assign out_valid     = out_valid_r;
  assign out_vertex    = out_v_r;
  assign out_last      = out_last_r;
  assign out_bad_start = out_bad_r;

endmodule
`default_nettype wire

>>> src/graph_traversal_bfs_dfs_top.sv
`default_nettype none
// channel   dir  payload                                           accepted when
// in_ch     in   operation, row_index, row_bits, start_vertex      valid && ready
// out_ch    out  vertex, last, bad_start                           valid && ready
// cfg       in   cfg_data (vertex_count)                           cfg_we
//
// a row write is stored as it is accepted; breadth-first spends a head read, a load,
// a closing scan and an enqueue per reached vertex, depth-first a push, a pop read and a
// reload, plus the accept and flush steps; the scan finds one candidate a cycle unless DFS output stalls
// synchronous active-low reset clears the adjacency rows, control and output register
// in_ch is taken only between traversals; results stall on out_ch.ready without loss

module graph_traversal_bfs_dfs_top #(
  parameter int NODES = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gtb_in_if.sink     in_ch,
  gtb_out_if.source  out_ch,
  input  wire logic       cfg_we,
  input  wire logic [5:0] cfg_data
);

  gtb_pkg::cmd_t cmd;
  gtb_pkg::sts_t sts;

  gtb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.operation),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gtb_dp #(.NODES(NODES)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_row_index    (in_ch.row_index),
    .in_row_bits     (in_ch.row_bits),
    .in_start_vertex (in_ch.start_vertex),
    .cmd             (cmd),
    .sts             (sts),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_vertex      (out_ch.vertex),
    .out_last        (out_ch.last),
    .out_bad_start   (out_ch.bad_start)
  );

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !sts.pend_valid) else $error("pending item while idle");
  a_push_has_cand: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_bfs || cmd.push_dfs) |-> sts.cand_any) else $error("push without candidate");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd)) else $error("more than one command");
  a_flush_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.flush |=> (out_ch.valid && out_ch.last)) else $error("flush gave no last item");
`endif

endmodule
`default_nettype wire

>>> tb/gtb_traversal_checker.sv
`default_nettype none
module gtb_traversal_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  gtb_in_if               in_ch,
  gtb_out_if              out_ch,
  input  wire logic       cfg_we,
  input  wire logic [5:0] cfg_data,
  output int              mismatches,
  output int              pending
);

  typedef struct packed {
    logic [gtb_pkg::VW-1:0] vertex;
    logic                   last;
    logic                   bad_start;
  } visit_t;

  visit_t                 visit_q[$];
  logic [31:0]            adj_rows [gtb_pkg::ROWS];
  logic [31:0]            seen;
  logic [5:0]             vcount;
  logic [gtb_pkg::VW-1:0] walk [gtb_pkg::ROWS];
  int                     walk_len;

  assign pending = visit_q.size();

  function automatic int live_vertices();
    return (vcount > 6'd32) ? 32 : int'(vcount);
  endfunction

  task automatic walk_bfs(input logic [gtb_pkg::VW-1:0] start, input int n);
    logic [gtb_pkg::VW-1:0] fifo [gtb_pkg::ROWS];
    int hd, tl;
    logic [gtb_pkg::VW-1:0] cur;
    hd = 0;
    tl = 1;
    fifo[0] = start;
    seen[start] = 1'b1;
    while (hd < tl) begin
      cur = fifo[hd];
      hd++;
      walk[walk_len] = cur;
      walk_len++;
      for (int i = 0; i < n; i++) begin
        if (adj_rows[cur][i] && !seen[i] && tl < gtb_pkg::ROWS) begin
          fifo[tl] = gtb_pkg::VW'(i);
          tl++;
          seen[i] = 1'b1;
        end
      end
    end
  endtask

  task automatic walk_dfs(input logic [gtb_pkg::VW-1:0] start, input int n);
    logic [gtb_pkg::VW-1:0] stk_v [gtb_pkg::ROWS];
    int stk_nx [gtb_pkg::ROWS];
    int depth, i;
    logic [gtb_pkg::VW-1:0] cur;
    logic pushed;
    seen[start] = 1'b1;
    walk[walk_len] = start;
    walk_len++;
    stk_v[0] = start;
    stk_nx[0] = 0;
    depth = 1;
    while (depth > 0) begin
      cur = stk_v[depth-1];
      pushed = 1'b0;
      for (i = stk_nx[depth-1]; i < n; i++) begin
        if (adj_rows[cur][i] && !seen[i]) begin
          stk_nx[depth-1] = i + 1;
          seen[i] = 1'b1;
          walk[walk_len] = gtb_pkg::VW'(i);
          walk_len++;
          // stack is bounded; a vertex found at full depth is emitted but not descended
          if (depth < gtb_pkg::ROWS) begin
            stk_v[depth] = gtb_pkg::VW'(i);
            stk_nx[depth] = 0;
            depth++;
          end
          pushed = 1'b1;
          break;
        end
      end
      if (!pushed) depth--;
    end
  endtask

  task automatic predict_item(input logic [1:0] op, input logic [4:0] row,
                              input logic [31:0] bits, input logic [4:0] start);
    int n;
    visit_t v;
    n = live_vertices();
    if (op == gtb_pkg::OP_WRITE) begin
      adj_rows[row] = bits;
    end else if (op != gtb_pkg::OP_NONE) begin
      if (int'(start) >= n) begin
        v.vertex = '0;
        v.last = 1'b1;
        v.bad_start = 1'b1;
        visit_q.push_back(v);
      end else begin
        seen = '0;
        walk_len = 0;
        if (op == gtb_pkg::OP_BFS) walk_bfs(start, n);
        else walk_dfs(start, n);
        for (int j = 0; j < walk_len; j++) begin
          v.vertex = walk[j];
          v.last = (j == walk_len - 1);
          v.bad_start = 1'b0;
          visit_q.push_back(v);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    visit_t want;
    if (!rst_n) begin
      for (int r = 0; r < gtb_pkg::ROWS; r++) adj_rows[r] = '0;
      seen = '0;
      vcount <= 6'd32;
      visit_q.delete();
      mismatches <= 0;
    end else begin
      if (cfg_we) vcount <= cfg_data;
      if (in_ch.valid && in_ch.ready)
        predict_item(in_ch.operation, in_ch.row_index, in_ch.row_bits, in_ch.start_vertex);
      if (out_ch.valid && out_ch.ready) begin
        if (visit_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: vertex %0d last %0b bad %0b",
                     out_ch.vertex, out_ch.last, out_ch.bad_start);
          mismatches <= mismatches + 1;
        end else begin
          want = visit_q.pop_front();
          if (want.vertex !== out_ch.vertex || want.last !== out_ch.last ||
              want.bad_start !== out_ch.bad_start) begin
            if (mismatches < 10)
              $display("mismatch: expected vertex %0d last %0b bad %0b, got %0d %0b %0b",
                       want.vertex, want.last, want.bad_start,
                       out_ch.vertex, out_ch.last, out_ch.bad_start);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> tb/tb_graph_traversal_bfs_dfs_top.sv
`default_nettype none
module tb_graph_traversal_bfs_dfs_top;

  localparam int IDLE_LIMIT = 5000;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [5:0] cfg_data;
  int         mismatches;
  int         pending;
  int         burst_left;
  int         stall_mode;
  int         quiet_cycles;

  gtb_in_if  in_ch ();
  gtb_out_if out_ch ();

  graph_traversal_bfs_dfs_top #(.NODES(32)) u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  gtb_traversal_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: switches between always ready, random stalls and long stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_mode   <= 0;
      out_ch.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 1);
        default: out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic send_item(input gtb_pkg::op_t op, input logic [4:0] row,
                           input logic [31:0] bits, input logic [4:0] start);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.row_index <= row;
    in_ch.row_bits <= bits;
    in_ch.start_vertex <= start;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_and_config(input logic [5:0] count);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] random_row();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return $urandom();
      default: return $urandom() & $urandom() & $urandom();
    endcase
  endfunction

  task automatic random_item(input int count);
    int pick;
    logic [4:0] start;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 4) == 0) start = 5'($urandom_range(0, 31));
    else start = 5'($urandom_range(0, count - 1));
    if (pick < 55)
      send_item(gtb_pkg::OP_WRITE, 5'($urandom_range(0, 31)), random_row(), 5'($urandom()));
    else if (pick < 75)
      send_item(gtb_pkg::OP_BFS, 5'($urandom()), $urandom(), start);
    else if (pick < 96)
      send_item(gtb_pkg::OP_DFS, 5'($urandom()), $urandom(), start);
    else
      send_item(gtb_pkg::OP_NONE, 5'($urandom()), $urandom(), 5'($urandom()));
  endtask

  initial begin
    int count;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= gtb_pkg::OP_WRITE;
    in_ch.row_index <= '0;
    in_ch.row_bits <= '0;
    in_ch.start_vertex <= '0;
    burst_left = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    drain_and_config(6'd32);
    // empty graph from both ends, then row 0 connected to every vertex
    send_item(gtb_pkg::OP_BFS, 5'd0, 32'h0, 5'd0);
    send_item(gtb_pkg::OP_DFS, 5'd0, 32'h0, 5'd31);
    send_item(gtb_pkg::OP_WRITE, 5'd0, 32'hffff_ffff, 5'd0);
    send_item(gtb_pkg::OP_BFS, 5'd0, 32'h0, 5'd0);
    send_item(gtb_pkg::OP_DFS, 5'd0, 32'h0, 5'd0);
    send_item(gtb_pkg::OP_NONE, 5'd31, 32'hffff_ffff, 5'd31);
    // chain for maximal stack depth
    for (int i = 0; i < 31; i++)
      send_item(gtb_pkg::OP_WRITE, 5'(i), 32'h1 << (i + 1), 5'd0);
    send_item(gtb_pkg::OP_WRITE, 5'd31, 32'h1, 5'd0);
    send_item(gtb_pkg::OP_DFS, 5'd0, 32'h0, 5'd0);
    send_item(gtb_pkg::OP_BFS, 5'd0, 32'h0, 5'd31);

    drain_and_config(6'd1);
    send_item(gtb_pkg::OP_BFS, 5'd0, 32'h0, 5'd0);
    send_item(gtb_pkg::OP_DFS, 5'd0, 32'h0, 5'd1);
    send_item(gtb_pkg::OP_BFS, 5'd0, 32'h0, 5'd31);

    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: count = 32;
        1: count = 2;
        2: count = 1;
        3: count = 32;
        default: count = $urandom_range(1, 32);
      endcase
      drain_and_config(6'(count));
      for (int k = 0; k < 40; k++) random_item(count);
    end

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
